// ===== rtl/kissci_pkg.sv =====
// ----------------------------------------------------------------------------
// kissci_pkg
// Shared constants and types of the KISS radio command interpreter: framing
// bytes, command codes and the reply job that runs from front end to back end.
// ----------------------------------------------------------------------------
package kissci_pkg;

  // KISS framing bytes
  localparam logic [7:0] K_FEND  = 8'hC0;
  localparam logic [7:0] K_FESC  = 8'hDB;
  localparam logic [7:0] K_TFEND = 8'hDC;
  localparam logic [7:0] K_TFESC = 8'hDD;

  // Command codes
  localparam logic [7:0] OP_DATA    = 8'h00;
  localparam logic [7:0] OP_FREQ    = 8'h01;
  localparam logic [7:0] OP_BW      = 8'h02;
  localparam logic [7:0] OP_POWER   = 8'h03;
  localparam logic [7:0] OP_SF      = 8'h04;
  localparam logic [7:0] OP_CR      = 8'h05;
  localparam logic [7:0] OP_DETECT  = 8'h08;
  localparam logic [7:0] OP_VERSION = 8'h50;
  localparam logic [7:0] OP_UNKNOWN = 8'hFE;

  // Payload values with a fixed meaning
  localparam logic [7:0] DETECT_ASK     = 8'h73;
  localparam logic [7:0] DETECT_ANSWER  = 8'h46;
  localparam logic [7:0] READ_ONLY_BYTE = 8'hFF;
  localparam logic [7:0] VERSION_HI     = 8'h01;
  localparam logic [7:0] VERSION_LO     = 8'h55;

  // Reply lengths in data bytes
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_BYTE = 3'd1;
  localparam logic [2:0] LEN_PAIR = 3'd2;
  localparam logic [2:0] LEN_WORD = 3'd4;

  // One reply frame to be sent: command byte and up to four data bytes
  typedef struct packed {
    logic [7:0]      op;
    logic [3:0][7:0] data;
    logic [2:0]      len;
  } job_t;

endpackage

// ===== rtl/kissci_front.sv =====
// ----------------------------------------------------------------------------
// kissci_front
// Deframes host bytes, tracks the command and payload head, keeps the radio
// settings and issues one reply job per byte that calls for an answer.
// ----------------------------------------------------------------------------
module kissci_front #(
  parameter int MAX_PAYLOAD = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                byte_valid_i,
  input  logic [7:0]          byte_i,
  output logic                job_valid_o,
  output kissci_pkg::job_t    job_o
);
  import kissci_pkg::*;

  localparam int CntW = $clog2(MAX_PAYLOAD + 1);

  logic            inside_q, inside_d;
  logic            esc_q, esc_d;
  logic [7:0]      cmd_q, cmd_d;
  logic [CntW-1:0] count_q, count_d;
  logic [31:0]     freq_q, freq_d;
  logic [31:0]     bw_q, bw_d;
  logic [7:0]      power_q, power_d;
  logic [7:0]      spread_q, spread_d;
  logic [7:0]      coding_q, coding_d;
  logic [7:0]      head_q [4];
  logic            head_we;
  logic [7:0]      plain;
  logic [31:0]     word_in;
  logic            take_payload;
  logic [CntW-1:0] count_inc;

  // Undo the escape on a payload byte
  always_comb begin
    plain = byte_i;
    if (esc_q) begin
      if (byte_i == K_TFEND) begin
        plain = K_FEND;
      end else if (byte_i == K_TFESC) begin
        plain = K_FESC;
      end
    end
  end

  assign count_inc = count_q + CntW'(1);
  assign word_in   = {plain, head_q[2], head_q[1], head_q[0]};

  // Classify the byte and update framing state and settings
  always_comb begin
    inside_d     = inside_q;
    esc_d        = esc_q;
    cmd_d        = cmd_q;
    count_d      = count_q;
    freq_d       = freq_q;
    bw_d         = bw_q;
    power_d      = power_q;
    spread_d     = spread_q;
    coding_d     = coding_q;
    head_we      = 1'b0;
    take_payload = 1'b0;
    job_valid_o  = 1'b0;
    job_o        = '0;
    job_o.op     = cmd_q;
    if (byte_valid_i) begin
      if (inside_q && byte_i == K_FEND && cmd_q == OP_DATA) begin
        inside_d = 1'b0;
      end else if (byte_i == K_FEND) begin
        inside_d = 1'b1;
        cmd_d    = OP_UNKNOWN;
        count_d  = '0;
        esc_d    = 1'b0;
      end else if (inside_q && count_q == '0 && cmd_q == OP_UNKNOWN) begin
        cmd_d = byte_i;
      end else if (!inside_q) begin
        cmd_d = cmd_q;
      end else if (byte_i == K_FESC) begin
        esc_d = 1'b1;
      end else begin
        esc_d        = 1'b0;
        take_payload = count_q != CntW'(MAX_PAYLOAD);
      end
    end

    if (take_payload) begin
      head_we = count_q < CntW'(4);
      count_d = count_inc;
      unique case (cmd_q)
        OP_FREQ: begin
          if (count_inc == CntW'(4)) begin
            if (word_in != '0) freq_d = word_in;
            job_valid_o = 1'b1;
            job_o.data  = freq_d;
            job_o.len   = LEN_WORD;
          end
        end
        OP_BW: begin
          if (count_inc == CntW'(4)) begin
            if (word_in != '0) bw_d = word_in;
            job_valid_o = 1'b1;
            job_o.data  = bw_d;
            job_o.len   = LEN_WORD;
          end
        end
        OP_POWER: begin
          if (count_q == '0) begin
            if (plain != READ_ONLY_BYTE) power_d = plain;
            job_valid_o   = 1'b1;
            job_o.data[0] = power_d;
            job_o.len     = LEN_BYTE;
          end
        end
        OP_SF: begin
          if (count_q == '0) begin
            if (plain != READ_ONLY_BYTE) spread_d = plain;
            job_valid_o   = 1'b1;
            job_o.data[0] = spread_d;
            job_o.len     = LEN_BYTE;
          end
        end
        OP_CR: begin
          if (count_q == '0) begin
            if (plain != READ_ONLY_BYTE) coding_d = plain;
            job_valid_o   = 1'b1;
            job_o.data[0] = coding_d;
            job_o.len     = LEN_BYTE;
          end
        end
        OP_DETECT: begin
          if (count_q == '0 && plain == DETECT_ASK) begin
            job_valid_o   = 1'b1;
            job_o.data[0] = DETECT_ANSWER;
            job_o.len     = LEN_BYTE;
          end
        end
        OP_VERSION: begin
          job_valid_o   = 1'b1;
          job_o.data[0] = VERSION_HI;
          job_o.data[1] = VERSION_LO;
          job_o.len     = LEN_PAIR;
        end
        default: begin
          job_o.len = LEN_NONE;
        end
      endcase
    end
  end

  // Hold framing state and settings
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      esc_q    <= 1'b0;
      cmd_q    <= OP_UNKNOWN;
      count_q  <= '0;
      freq_q   <= '0;
      bw_q     <= '0;
      power_q  <= '0;
      spread_q <= '0;
      coding_q <= '0;
    end else begin
      inside_q <= inside_d;
      esc_q    <= esc_d;
      cmd_q    <= cmd_d;
      count_q  <= count_d;
      freq_q   <= freq_d;
      bw_q     <= bw_d;
      power_q  <= power_d;
      spread_q <= spread_d;
      coding_q <= coding_d;
    end
  end

  // Keep the first four payload bytes of the frame
  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_q[count_q[1:0]] <= plain;
    end
  end

endmodule

// ===== rtl/kissci_job_fifo.sv =====
// ----------------------------------------------------------------------------
// kissci_job_fifo
// Two-entry queue of reply jobs between the front end and the back end.
// ----------------------------------------------------------------------------
module kissci_job_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  kissci_pkg::job_t    wr_job_i,
  output logic                full_o,
  input  logic                rd_en_i,
  output logic                valid_o,
  output kissci_pkg::job_t    rd_job_o
);
  import kissci_pkg::*;

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o   = count_q == 2'd2;
  assign valid_o  = count_q != 2'd0;
  assign rd_job_o = mem_q[rd_ptr_q];

  // Store the incoming job
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (wr_en_i) wr_ptr_q <= ~wr_ptr_q;
      if (rd_en_i) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, wr_en_i} - {1'b0, rd_en_i};
    end
  end

endmodule

// ===== rtl/kissci_back.sv =====
// ----------------------------------------------------------------------------
// kissci_back
// Serializes one reply job into an escaped KISS frame, one byte per cycle while
// the consumer keeps popping, into an output register that the consumer pops.
// ----------------------------------------------------------------------------
module kissci_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  kissci_pkg::job_t    job_i,
  output logic                job_done_o,
  output logic                empty,
  input  logic                pop,
  output logic [7:0]          reply_byte_o,
  output logic                frame_end_o
);
  import kissci_pkg::*;

  localparam logic [1:0] PH_OPEN  = 2'd0;
  localparam logic [1:0] PH_OP    = 2'd1;
  localparam logic [1:0] PH_DATA  = 2'd2;
  localparam logic [1:0] PH_CLOSE = 2'd3;

  logic [1:0] phase_q, phase_d;
  logic [1:0] idx_q, idx_d;
  logic       esc_q, esc_d;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_end_q;
  logic       load;
  logic [7:0] emit_byte;
  logic       emit_end;
  logic [7:0] cur;

  assign load = job_valid_i && (!out_valid_q || pop);
  assign cur  = job_i.data[idx_q];

  // Pick the next frame byte and step the sequencer
  always_comb begin
    phase_d    = phase_q;
    idx_d      = idx_q;
    esc_d      = esc_q;
    emit_byte  = K_FEND;
    emit_end   = 1'b0;
    job_done_o = 1'b0;
    unique case (phase_q)
      PH_OPEN: begin
        emit_byte = K_FEND;
        if (load) phase_d = PH_OP;
      end
      PH_OP: begin
        emit_byte = job_i.op;
        if (load) begin
          phase_d = PH_DATA;
          idx_d   = 2'd0;
        end
      end
      PH_DATA: begin
        if (esc_q) begin
          emit_byte = (cur == K_FEND) ? K_TFEND : K_TFESC;
        end else if (cur == K_FEND || cur == K_FESC) begin
          emit_byte = K_FESC;
        end else begin
          emit_byte = cur;
        end
        if (load) begin
          if (!esc_q && (cur == K_FEND || cur == K_FESC)) begin
            esc_d = 1'b1;
          end else begin
            esc_d = 1'b0;
            if ({1'b0, idx_q} == job_i.len - 3'd1) begin
              phase_d = PH_CLOSE;
            end else begin
              idx_d = idx_q + 2'd1;
            end
          end
        end
      end
      PH_CLOSE: begin
        emit_byte = K_FEND;
        emit_end  = 1'b1;
        if (load) begin
          phase_d    = PH_OPEN;
          job_done_o = 1'b1;
        end
      end
      default: begin
        phase_d = PH_OPEN;
      end
    endcase
  end

  // Hold sequencer state and the output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_OPEN;
      idx_q       <= 2'd0;
      esc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      esc_q   <= esc_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= emit_byte;
      out_end_q  <= emit_end;
    end
  end

  assign empty        = !out_valid_q;
  assign reply_byte_o = out_byte_q;
  assign frame_end_o  = out_end_q;

  // A closing word is always the frame delimiter
  a_end_is_fend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && frame_end_o) |-> (reply_byte_o == K_FEND))
    else $error("frame end flagged on a byte other than FEND");

  // Escape second half only pending inside the data bytes
  a_esc_in_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> (phase_q == PH_DATA))
    else $error("escape pending outside data phase");

  // A job retires only after its closing word is loaded
  a_done_loads_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_done_o |=> (!empty && frame_end_o))
    else $error("job retired without a closing FEND in the output");

endmodule

// ===== rtl/kiss_radio_command_interpreter.sv =====
// ----------------------------------------------------------------------------
// kiss_radio_command_interpreter
// KISS command interpreter for a radio modem: deframes host bytes, keeps the
// radio settings and sends escaped reply frames.
//
//   channel   direction  handshake          payload
//   host      in         push / full        host_byte_i
//   reply     out        pop / empty        reply_byte_o, frame_end_o
//
// A host word is taken back to back while full is low; the front end
// classifies it in that same cycle and queues at most one reply job.
// The back end emits one reply word per cycle while pop keeps up: a reply
// frame holds 4 to 11 words (two FENDs, the command, up to four data words,
// each escaped to two). full rises only when the two-entry job queue is full;
// a stalled pop holds the output word and backs up the queue. Reset at once
// clears framing state and settings and empties job queue and output register.
// ----------------------------------------------------------------------------
module kiss_radio_command_interpreter #(
  parameter int MAX_PAYLOAD = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] host_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] reply_byte_o,
  output logic       frame_end_o
);
  import kissci_pkg::*;

  logic fifo_full;
  logic accept;
  logic front_job_valid;
  job_t front_job;
  logic back_job_valid;
  job_t back_job;
  logic back_job_done;

  assign full   = fifo_full;
  assign accept = push && !fifo_full;

  // Classify host words
  kissci_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(accept),
    .byte_i      (host_byte_i),
    .job_valid_o (front_job_valid),
    .job_o       (front_job)
  );

  // Decouple front and back
  kissci_job_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (front_job_valid),
    .wr_job_i(front_job),
    .full_o  (fifo_full),
    .rd_en_i (back_job_done),
    .valid_o (back_job_valid),
    .rd_job_o(back_job)
  );

  // Serialize reply frames
  kissci_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (back_job_valid),
    .job_i       (back_job),
    .job_done_o  (back_job_done),
    .empty       (empty),
    .pop         (pop),
    .reply_byte_o(reply_byte_o),
    .frame_end_o (frame_end_o)
  );

endmodule
